@@ src/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere generator package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package uvs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] CFG_SLICES = 2'd0;
    localparam logic [1:0] CFG_STACKS = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_vec_t;

    function automatic logic signed [CW-1:0] atan_turns(input logic [3:0] k);
        logic signed [CW-1:0] r;
        begin
            case (k)
                4'd0:    r = 34'sd536870912;
                4'd1:    r = 34'sd316933406;
                4'd2:    r = 34'sd167458907;
                4'd3:    r = 34'sd85004756;
                4'd4:    r = 34'sd42667331;
                4'd5:    r = 34'sd21354465;
                4'd6:    r = 34'sd10679838;
                4'd7:    r = 34'sd5340245;
                4'd8:    r = 34'sd2670163;
                4'd9:    r = 34'sd1335087;
                4'd10:   r = 34'sd667544;
                4'd11:   r = 34'sd333772;
                4'd12:   r = 34'sd166886;
                4'd13:   r = 34'sd83443;
                4'd14:   r = 34'sd41722;
                default: r = 34'sd20861;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/uvs_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step, registered, with a payload that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module uvs_cordic_cell #(
    parameter int STEP = 0,
    parameter int PW   = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire uvs_pkg::cordic_vec_t  in_a,
    input  wire uvs_pkg::cordic_vec_t  in_b,
    input  wire logic [PW-1:0]         in_pay,
    output logic                       out_vld,
    output uvs_pkg::cordic_vec_t       out_a,
    output uvs_pkg::cordic_vec_t       out_b,
    output logic [PW-1:0]              out_pay
);
    function automatic uvs_pkg::cordic_vec_t rot(input uvs_pkg::cordic_vec_t v);
        uvs_pkg::cordic_vec_t r;
        begin
            if (!v.z[uvs_pkg::CW-1]) begin
                r.x = v.x - (v.y >>> STEP);
                r.y = v.y + (v.x >>> STEP);
                r.z = v.z - uvs_pkg::atan_turns(4'(STEP));
            end else begin
                r.x = v.x + (v.y >>> STEP);
                r.y = v.y - (v.x >>> STEP);
                r.z = v.z + uvs_pkg::atan_turns(4'(STEP));
            end
            return r;
        end
    endfunction

    logic vld_reg;
    uvs_pkg::cordic_vec_t a_reg, b_reg;
    logic [PW-1:0] pay_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_reg   <= rot(in_a);
            b_reg   <= rot(in_b);
            pay_reg <= in_pay;
        end
    end

    assign out_vld = vld_reg;
    assign out_a   = a_reg;
    assign out_b   = b_reg;
    assign out_pay = pay_reg;
endmodule
`default_nettype wire

@@ src/uvs_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for two unsigned divisions, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module uvs_div_cell #(
    parameter int NW = 40,
    parameter int PW = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire logic [NW-1:0]  in_rem_a,
    input  wire logic [NW-1:0]  in_num_a,
    input  wire logic [7:0]     in_den_a,
    input  wire logic [NW-1:0]  in_rem_b,
    input  wire logic [NW-1:0]  in_num_b,
    input  wire logic [7:0]     in_den_b,
    input  wire logic [PW-1:0]  in_pay,
    output logic                out_vld,
    output logic [NW-1:0]       out_rem_a,
    output logic [NW-1:0]       out_num_a,
    output logic [7:0]          out_den_a,
    output logic [NW-1:0]       out_rem_b,
    output logic [NW-1:0]       out_num_b,
    output logic [7:0]          out_den_b,
    output logic [PW-1:0]       out_pay
);
    // rem holds a 9-bit partial remainder; num shifts left, quotient enters at LSB
    logic [8:0] ta, tb;
    logic [9:0] da, db;
    logic       vld_reg;
    logic [NW-1:0] rem_a_reg, num_a_reg, rem_b_reg, num_b_reg;
    logic [7:0] den_a_reg, den_b_reg;
    logic [PW-1:0] pay_reg;

    always_comb begin
        da = {in_rem_a[8:0], in_num_a[NW-1]} - {2'b00, in_den_a};
        db = {in_rem_b[8:0], in_num_b[NW-1]} - {2'b00, in_den_b};
        ta = da[9] ? {in_rem_a[7:0], in_num_a[NW-1]} : da[8:0];
        tb = db[9] ? {in_rem_b[7:0], in_num_b[NW-1]} : db[8:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rem_a_reg <= {{(NW-9){1'b0}}, ta};
            rem_b_reg <= {{(NW-9){1'b0}}, tb};
            num_a_reg <= {in_num_a[NW-2:0], ~da[9]};
            num_b_reg <= {in_num_b[NW-2:0], ~db[9]};
            den_a_reg <= in_den_a;
            den_b_reg <= in_den_b;
            pay_reg   <= in_pay;
        end
    end

    assign out_vld   = vld_reg;
    assign out_rem_a = rem_a_reg;
    assign out_num_a = num_a_reg;
    assign out_den_a = den_a_reg;
    assign out_rem_b = rem_b_reg;
    assign out_num_b = num_b_reg;
    assign out_den_b = den_b_reg;
    assign out_pay   = pay_reg;
endmodule
`default_nettype wire

@@ src/uv_sphere_mesh_generator.sv @@
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// Vertex and triangle-index generator for a UV sphere; divider chain, CORDIC
// chain and product stages, all stalling together on output backpressure.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | req_type, slice_index, stack_index
//  out     | out_valid/out_ready| pos_*, norm_*, tex_*, corner_*, last
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//  Path: divider cells, CORDIC cells, stages s1 to s4, output registers; one
//  vertex or pole cell per cycle unless out_ready stalls; a middle cell gives
//  two triangles and holds the input while the second is pending. All chain
//  cells advance together; a full output stage with out_ready low holds the
//  whole pipeline. Reset loads the counts to 10 and radius to 128 and empties it.
// ----------------------------------------------------------------------------
`default_nettype none
module uv_sphere_mesh_generator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [7:0]         slice_index,
    input  wire logic [7:0]         stack_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [16:0]      pos_x,
    output logic signed [16:0]      pos_y,
    output logic signed [16:0]      pos_z,
    output logic signed [15:0]      norm_x,
    output logic signed [15:0]      norm_y,
    output logic signed [15:0]      norm_z,
    output logic [16:0]             tex_s,
    output logic [16:0]             tex_t,
    output logic [15:0]             corner_a,
    output logic [15:0]             corner_b,
    output logic [15:0]             corner_c,
    output logic                    last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    localparam int CW = uvs_pkg::CW;
    localparam int NS = uvs_pkg::CORDIC_STEPS;
    localparam int DN = 40;   // 32 quotient bits plus guard
    localparam int DQ = 32;
    // payload: type, i, j, sl, st, rad
    localparam int PW = 1 + 8 + 8 + 8 + 8 + 16;

    logic [7:0]  slices_reg, stacks_reg;
    logic [15:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slices_reg <= 8'd10;
            stacks_reg <= 8'd10;
            radius_reg <= 16'd128;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                uvs_pkg::CFG_SLICES: slices_reg <= cfg_data[7:0];
                uvs_pkg::CFG_STACKS: stacks_reg <= cfg_data[7:0];
                uvs_pkg::CFG_RADIUS: radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // ---------------- output stage (two-deep: current + pending second tri)
    logic        ov_reg, second_reg;
    logic        en;
    logic        fin_vld;
    logic        fin_second;

    // chain advances when output stage will be free
    assign en = !ov_reg || (out_ready && !second_reg);
    assign in_ready = en;

    // ---------------- input decode
    logic [7:0] sl, st, vi, vj;
    always_comb begin
        sl = (slices_reg == 8'd0) ? 8'd1 : slices_reg;
        st = (stacks_reg < 8'd2) ? 8'd2 : stacks_reg;
        if (!req_type) begin
            vi = (slice_index > sl) ? sl : slice_index;
            vj = (stack_index > st) ? st : stack_index;
        end else begin
            vi = (slice_index > sl - 8'd1) ? sl - 8'd1 : slice_index;
            vj = (stack_index > st - 8'd1) ? st - 8'd1 : stack_index;
        end
    end

    // ---------------- divider chain: theta=i*2^32/sl, phi=j*2^31/st
    // numerator a = i<<32 (width DN), b = j<<31
    logic            dv [0:DQ];
    logic [DN-1:0]   dra [0:DQ], dna [0:DQ], drb [0:DQ], dnb [0:DQ];
    logic [7:0]      dda [0:DQ], ddb [0:DQ];
    logic [PW-1:0]   dp  [0:DQ];

    // the remainder is preloaded with the top numerator bits; the cell
    // consumes the numerator MSB each step.
    // i == sl wraps to theta 0, so it starts from a zero remainder.
    assign dv[0]  = in_valid && in_ready;
    assign dra[0] = (vi == sl) ? '0 : {{(DN-8){1'b0}}, vi};
    assign dna[0] = '0;
    assign drb[0] = {{(DN-8){1'b0}}, 1'b0, vj[7:1]};
    assign dnb[0] = {vj[0], {(DN-1){1'b0}}};
    assign dda[0] = sl;
    assign ddb[0] = st;
    assign dp[0]  = {req_type, vi, vj, sl, st, radius_reg};

    genvar g;
    generate
        for (g = 0; g < DQ; g++) begin : g_div
            uvs_div_cell #(.NW(DN), .PW(PW)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(dv[g]),
                .in_rem_a(dra[g]), .in_num_a(dna[g]), .in_den_a(dda[g]),
                .in_rem_b(drb[g]), .in_num_b(dnb[g]), .in_den_b(ddb[g]),
                .in_pay(dp[g]), .out_vld(dv[g+1]),
                .out_rem_a(dra[g+1]), .out_num_a(dna[g+1]), .out_den_a(dda[g+1]),
                .out_rem_b(drb[g+1]), .out_num_b(dnb[g+1]), .out_den_b(ddb[g+1]),
                .out_pay(dp[g+1])
            );
        end
    endgenerate

    logic [31:0] theta, phi;
    assign theta = dna[DQ][31:0];
    assign phi   = dnb[DQ][31:0];

    // ---------------- CORDIC chain
    localparam int CP = PW + 4;
    logic                 cv [0:NS];
    uvs_pkg::cordic_vec_t ca [0:NS], cb [0:NS];
    logic [CP-1:0]        cpay [0:NS];

    assign cv[0]   = dv[DQ];
    assign ca[0]   = '{x: uvs_pkg::CORDIC_GAIN, y: '0, z: {4'b0000, theta[29:0]}};
    assign cb[0]   = '{x: uvs_pkg::CORDIC_GAIN, y: '0, z: {4'b0000, phi[29:0]}};
    assign cpay[0] = {theta[31:30], phi[31:30], dp[DQ]};

    generate
        for (g = 0; g < NS; g++) begin : g_cor
            uvs_cordic_cell #(.STEP(g), .PW(CP)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(cv[g]),
                .in_a(ca[g]), .in_b(cb[g]), .in_pay(cpay[g]),
                .out_vld(cv[g+1]), .out_a(ca[g+1]), .out_b(cb[g+1]),
                .out_pay(cpay[g+1])
            );
        end
    endgenerate

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            r = (v + 34'sd16384) >>> 15;
            if (r > 34'sd32767) return 16'sh7fff;
            else if (r < -34'sd32768) return 16'sh8000;
            else return r[15:0];
        end
    endfunction

    function automatic logic signed [CW-1:0] qsel_c(input logic [1:0] q,
                                                   input uvs_pkg::cordic_vec_t v);
        case (q)
            2'd0:    return v.x;
            2'd1:    return -v.y;
            2'd2:    return -v.x;
            default: return v.y;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] qsel_s(input logic [1:0] q,
                                                   input uvs_pkg::cordic_vec_t v);
        case (q)
            2'd0:    return v.y;
            2'd1:    return v.x;
            2'd2:    return -v.y;
            default: return -v.x;
        endcase
    endfunction

    // stage s1: quadrant fold and rounding
    logic [PW-1:0]       pay_s1;
    logic                v_s1;
    logic signed [15:0]  st_s1, ct_s1, sp_s1, cp_s1;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v_s1 <= 1'b0;
        else if (en) v_s1 <= cv[NS];
    end
    always_ff @(posedge clk) begin
        if (en) begin
            st_s1  <= to_q15(qsel_s(cpay[NS][CP-1:CP-2], ca[NS]));
            ct_s1  <= to_q15(qsel_c(cpay[NS][CP-1:CP-2], ca[NS]));
            sp_s1  <= to_q15(qsel_s(cpay[NS][CP-3:CP-4], cb[NS]));
            cp_s1  <= to_q15(qsel_c(cpay[NS][CP-3:CP-4], cb[NS]));
            pay_s1 <= cpay[NS][PW-1:0];
        end
    end

    // stage s2: normal products
    function automatic logic signed [15:0] rq15(input logic signed [31:0] p);
        logic signed [31:0] r;
        begin
            r = (p + 32'sd16384) >>> 15;
            if (r > 32'sd32767) return 16'sh7fff;
            else if (r < -32'sd32768) return 16'sh8000;
            else return r[15:0];
        end
    endfunction

    logic                v_s2;
    logic [PW-1:0]       pay_s2;
    logic signed [31:0]  px_s2, py_s2;
    logic signed [15:0]  nz_s2;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v_s2 <= 1'b0;
        else if (en) v_s2 <= v_s1;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            px_s2  <= sp_s1 * ct_s1;
            py_s2  <= sp_s1 * st_s1;
            nz_s2  <= cp_s1;
            pay_s2 <= pay_s1;
        end
    end

    // stage s3: round normals
    logic                v_s3;
    logic [PW-1:0]       pay_s3;
    logic signed [15:0]  nx_s3, ny_s3, nz_s3;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v_s3 <= 1'b0;
        else if (en) v_s3 <= v_s2;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            nx_s3  <= rq15(px_s2);
            ny_s3  <= rq15(py_s2);
            nz_s3  <= nz_s2;
            pay_s3 <= pay_s2;
        end
    end

    // stage s4: radius products, texture numerators
    logic [15:0] rad3;
    assign rad3 = pay_s3[15:0];
    logic                v_s4;
    logic [PW-1:0]       pay_s4;
    logic signed [15:0]  nx_s4, ny_s4, nz_s4;
    logic signed [32:0]  rx_s4, ry_s4, rz_s4;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v_s4 <= 1'b0;
        else if (en) v_s4 <= v_s3;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            rx_s4  <= $signed({1'b0, rad3}) * nx_s3;
            ry_s4  <= $signed({1'b0, rad3}) * ny_s3;
            rz_s4  <= $signed({1'b0, rad3}) * nz_s3;
            nx_s4  <= nx_s3;
            ny_s4  <= ny_s3;
            nz_s4  <= nz_s3;
            pay_s4 <= pay_s3;
        end
    end

    function automatic logic signed [16:0] rpos(input logic signed [32:0] p);
        logic signed [32:0] r;
        begin
            r = (p + 33'sd16384) >>> 15;
            if (r > 33'sd65535) return 17'sd65535;
            else if (r < -33'sd65535) return -17'sd65535;
            else return r[16:0];
        end
    endfunction

    // texture: round(i*65536/sl) equals floor((i*2^17/sl + 1)/2), and
    // i*2^17/sl = theta>>15 for i < sl; i == sl (theta wrapped) reads as 2^17.
    logic [17:0] ts_q, tt_q;
    logic [16:0] tex_s4, tex_t4;
    // delayed alongside the CORDIC chain and the four product stages
    logic [17:0] tsq_p [0:NS+4], ttq_p [0:NS+4];
    assign tsq_p[0] = (dp[DQ][47:40] == dp[DQ][31:24]) ? 18'h20000 : {1'b0, theta[31:15]};
    assign ttq_p[0] = {phi[31:14]};
    generate
        for (g = 0; g < NS + 4; g++) begin : g_tq
            always_ff @(posedge clk) begin
                if (en) begin
                    tsq_p[g+1] <= tsq_p[g];
                    ttq_p[g+1] <= ttq_p[g];
                end
            end
        end
    endgenerate
    assign ts_q = tsq_p[NS+4];
    assign tt_q = ttq_p[NS+4];
    // phi = j*2^31/st exactly < 2^32 so j*2^17/st = phi>>14
    always_comb begin
        tex_s4 = 17'((ts_q + 18'd1) >> 1);
        tex_t4 = 17'((tt_q + 18'd1) >> 1);
    end

    // cell triangles from payload at s4 stage
    logic [7:0]  ci, cj, cst;
    logic [15:0] ss, ns;
    assign ci  = pay_s4[47:40];
    assign cj  = pay_s4[39:32];
    assign cst = pay_s4[15+8:16];
    always_comb begin
        ss = 16'(ci * ({8'd0, cst} + 16'd1));
        ns = ss + {8'd0, cst} + 16'd1;
    end

    // output registers
    logic signed [16:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic [16:0] ts_reg, tt_reg;
    logic [15:0] ca_reg, cb_reg, cc_reg;
    logic        last_reg;
    logic [15:0] ca2_reg, cb2_reg, cc2_reg;

    assign fin_vld = v_s4;
    assign fin_second = pay_s4[PW-1] && cj != 8'd0 && cj != cst - 8'd1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ov_reg     <= 1'b0;
            second_reg <= 1'b0;
        end else if (ov_reg && out_ready && second_reg) begin
            second_reg <= 1'b0;
        end else if (en) begin
            ov_reg     <= fin_vld;
            second_reg <= fin_vld && fin_second;
        end
    end

    always_ff @(posedge clk) begin
        if (ov_reg && out_ready && second_reg) begin
            ca_reg   <= ca2_reg;
            cb_reg   <= cb2_reg;
            cc_reg   <= cc2_reg;
            last_reg <= 1'b1;
        end else if (en) begin
            if (!pay_s4[PW-1]) begin
                px_reg <= rpos(rx_s4);
                py_reg <= rpos(ry_s4);
                pz_reg <= rpos(rz_s4);
                nx_reg <= nx_s4;
                ny_reg <= ny_s4;
                nz_reg <= nz_s4;
                ts_reg <= tex_s4;
                tt_reg <= tex_t4;
                ca_reg <= '0;
                cb_reg <= '0;
                cc_reg <= '0;
                last_reg <= 1'b1;
            end else begin
                px_reg <= '0;
                py_reg <= '0;
                pz_reg <= '0;
                nx_reg <= '0;
                ny_reg <= '0;
                nz_reg <= '0;
                ts_reg <= '0;
                tt_reg <= '0;
                if (cj == 8'd0) begin
                    ca_reg <= ss;
                    cb_reg <= ss + 16'd1;
                    cc_reg <= ns + 16'd1;
                    last_reg <= 1'b1;
                end else if (cj == cst - 8'd1) begin
                    ca_reg <= ss + {8'd0, cj};
                    cb_reg <= ss + {8'd0, cj} + 16'd1;
                    cc_reg <= ns + {8'd0, cj};
                    last_reg <= 1'b1;
                end else begin
                    ca_reg <= ss + {8'd0, cj};
                    cb_reg <= ss + {8'd0, cj} + 16'd1;
                    cc_reg <= ns + {8'd0, cj} + 16'd1;
                    last_reg <= 1'b0;
                end
            end
            ca2_reg <= ns + {8'd0, cj};
            cb2_reg <= ss + {8'd0, cj};
            cc2_reg <= ns + {8'd0, cj} + 16'd1;
        end
    end

    assign out_valid = ov_reg;
    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_z = pz_reg;
    assign norm_x = nx_reg;
    assign norm_y = ny_reg;
    assign norm_z = nz_reg;
    assign tex_s = ts_reg;
    assign tex_t = tt_reg;
    assign corner_a = ca_reg;
    assign corner_b = cb_reg;
    assign corner_c = cc_reg;
    assign last = last_reg;

`ifndef NO_ASSERTIONS
    a_second_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> ov_reg) else $error("second triangle without valid");
    a_second_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && second_reg) |-> !last_reg) else $error("first triangle marked last");
    a_hold_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !in_ready) else $error("input taken during second triangle");
`endif
endmodule
`default_nettype wire
